// ===== rtl/chb_pkg.sv =====
package chb_pkg;

  localparam int DefMaxSymbols    = 320;
  localparam int DefMaxCodeLength = 15;

  localparam logic [1:0] ReqLoad   = 2'd0;
  localparam logic [1:0] ReqBuild  = 2'd1;
  localparam logic [1:0] ReqDecode = 2'd2;
  localparam logic [1:0] ReqRoot   = 2'd3;

  localparam logic [2:0] StDone     = 3'd0;
  localparam logic [2:0] StBuildErr = 3'd1;
  localparam logic [2:0] StSymbol   = 3'd2;
  localparam logic [2:0] StNeedMore = 3'd3;
  localparam logic [2:0] StNoBranch = 3'd4;
  localparam logic [2:0] StNotBuilt = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT_RD,
    S_CNT_CHK,
    S_NXT,
    S_ASG_RD,
    S_ASG_LEN,
    S_CHK_RD,
    S_CHK_CMP,
    S_SCAN_RD,
    S_SCAN_CHK
  } state_t;

endpackage

// ===== rtl/chb_tables.sv =====
module chb_tables #(
  parameter int MAX_SYMBOLS = 320,
  parameter int SymW        = 9
) (
  input  logic            clk,
  input  logic            len_we,
  input  logic [SymW-1:0] len_waddr,
  input  logic [3:0]      len_wdata,
  input  logic            code_we,
  input  logic [SymW-1:0] code_waddr,
  input  logic [14:0]     code_wdata,
  input  logic [SymW-1:0] raddr,
  output logic [3:0]      len_rdata,
  output logic [14:0]     code_rdata
);

  logic [3:0]  len_mem  [MAX_SYMBOLS];
  logic [14:0] code_mem [MAX_SYMBOLS];

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_rdata <= len_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[code_waddr] <= code_wdata;
    end
    code_rdata <= code_mem[raddr];
  end

endmodule

// ===== rtl/canonical_huffman_build_and_decode_core.sv =====
// Channel   Handshake            Payload
// request   start / busy         req_type, symbol_index, code_length, symbol_count, bit_req
// result    done (one cycle)     status, symbol, path_bits, path_length
//
// Load and return-to-root finish in the cycle after they are accepted. A decode
// bit scans the active symbols, each with a memory read, then a compare.
// A build makes a counting pass, a first-code setup for lengths 1..15, then for
// each used symbol n an overlap check against symbols 0..n-1.
// Synchronous reset clears control state; the length and code memories are not
// cleared. The receiver cannot stall: a result shows for exactly one cycle.
module canonical_huffman_build_and_decode_core #(
  parameter int MAX_SYMBOLS     = chb_pkg::DefMaxSymbols,
  parameter int MAX_CODE_LENGTH = chb_pkg::DefMaxCodeLength
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [8:0]  symbol_index,
  input  logic [3:0]  code_length,
  input  logic [8:0]  symbol_count,
  input  logic        bit_req,
  output logic        done,
  output logic [2:0]  status,
  output logic [8:0]  symbol,
  output logic [14:0] path_bits,
  output logic [3:0]  path_length
);
  import chb_pkg::*;

  localparam int SymW     = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CntW     = $clog2(MAX_SYMBOLS + 1);
  localparam int LenLimit = (MAX_CODE_LENGTH < 15) ? MAX_CODE_LENGTH : 15;

  state_t state, state_next;

  logic [CntW-1:0] act, n, m;
  logic            valid;
  logic [14:0]     pval, pmsb;
  logic [3:0]      plen;
  logic [3:0]      len_n;
  logic [14:0]     c_n;
  logic [8:0]      cnt [16];
  logic [15:0]     nxt [16];
  logic [3:0]      b;
  logic            branch, found;
  logic [8:0]      fsym;
  logic [14:0]     npval, npmsb;
  logic [3:0]      nplen;

  logic            len_we, code_we;
  logic [SymW-1:0] raddr;
  logic [3:0]      len_rd;
  logic [14:0]     code_rd;

  logic            accept;
  logic            match;
  logic [15:0]     pmask, cmask, cand;
  logic            overlap;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  chb_tables #(.MAX_SYMBOLS(MAX_SYMBOLS), .SymW(SymW)) u_tables (
    .clk        (clk),
    .len_we     (len_we),
    .len_waddr  (SymW'(symbol_index)),
    .len_wdata  (code_length),
    .code_we    (code_we),
    .code_waddr (n[SymW-1:0]),
    .code_wdata (c_n),
    .raddr      (raddr),
    .len_rdata  (len_rd),
    .code_rdata (code_rd)
  );

  // Prefix compare: the code's top nplen bits against the walked bits.
  assign pmask = (16'd1 << nplen) - 16'd1;
  assign match = (len_rd != 4'd0) && (len_rd >= nplen) &&
                 ((({1'b0, code_rd} >> (len_rd - nplen)) & pmask) ==
                  ({1'b0, npmsb} & pmask));
  assign cmask = (16'd1 << len_rd) - 16'd1;
  assign cand  = nxt[len_rd] & cmask;
  assign overlap = (len_rd != 4'd0) && (len_rd <= len_n) &&
                   (code_rd == (c_n >> (len_n - len_rd)));

  always_comb begin
    state_next = state;
    len_we     = 1'b0;
    code_we    = 1'b0;
    raddr      = n[SymW-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req_type)
            ReqLoad:   len_we = (32'(symbol_index) < MAX_SYMBOLS);
            ReqBuild:  state_next = S_CNT_RD;
            ReqDecode: begin
              if (valid && plen < 4'd15) begin
                state_next = S_SCAN_RD;
              end
            end
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_CNT_RD:   state_next = (n == act) ? S_NXT : S_CNT_CHK;
      S_CNT_CHK:  state_next = (32'(len_rd) > LenLimit) ? S_IDLE : S_CNT_RD;
      S_NXT:      state_next = (b == 4'd15) ? S_ASG_RD : S_NXT;
      S_ASG_RD:   state_next = (n == act) ? S_IDLE : S_ASG_LEN;
      S_ASG_LEN:  state_next = (len_rd == 4'd0) ? S_ASG_RD : S_CHK_RD;
      S_CHK_RD: begin
        raddr = m[SymW-1:0];
        if (m == n) begin
          code_we    = 1'b1;
          state_next = S_ASG_RD;
        end else begin
          state_next = S_CHK_CMP;
        end
      end
      S_CHK_CMP:  state_next = overlap ? S_IDLE : S_CHK_RD;
      S_SCAN_RD:  state_next = (n == act) ? S_IDLE : S_SCAN_CHK;
      S_SCAN_CHK: state_next = S_SCAN_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      valid <= 1'b0;
      act   <= '0;
      pval  <= '0;
      pmsb  <= '0;
      plen  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status      <= StDone;
            symbol      <= '0;
            path_bits   <= '0;
            path_length <= '0;
            unique case (req_type)
              ReqLoad: begin
                valid <= 1'b0;
                pval  <= '0;
                pmsb  <= '0;
                plen  <= '0;
                done  <= 1'b1;
              end
              ReqBuild: begin
                act  <= (32'(symbol_count) > MAX_SYMBOLS) ? CntW'(MAX_SYMBOLS)
                                                          : CntW'(symbol_count);
                pval <= '0;
                pmsb <= '0;
                plen <= '0;
                n    <= '0;
                for (int i = 0; i < 16; i++) begin
                  cnt[i] <= '0;
                end
              end
              ReqDecode: begin
                if (!valid) begin
                  status <= StNotBuilt;
                  done   <= 1'b1;
                end else if (plen >= 4'd15) begin
                  status <= StNoBranch;
                  done   <= 1'b1;
                end
                npval  <= pval | (15'(bit_req) << plen);
                npmsb  <= {pmsb[13:0], bit_req};
                nplen  <= plen + 4'd1;
                n      <= '0;
                branch <= 1'b0;
                found  <= 1'b0;
                fsym   <= '0;
              end
              default: begin
                pval <= '0;
                pmsb <= '0;
                plen <= '0;
                done <= 1'b1;
              end
            endcase
          end
        end
        S_CNT_RD: begin
          if (n == act) begin
            cnt[0] <= '0;
            nxt[0] <= '0;
            b      <= 4'd1;
          end
        end
        S_CNT_CHK: begin
          if (32'(len_rd) > LenLimit) begin
            valid  <= 1'b0;
            status <= StBuildErr;
            done   <= 1'b1;
          end else begin
            cnt[len_rd] <= cnt[len_rd] + 9'd1;
            n           <= n + CntW'(1);
          end
        end
        S_NXT: begin
          nxt[b] <= (nxt[b - 4'd1] + {7'd0, cnt[b - 4'd1]}) << 1;
          b      <= b + 4'd1;
          n      <= '0;
        end
        S_ASG_RD: begin
          if (n == act) begin
            valid  <= 1'b1;
            status <= StDone;
            done   <= 1'b1;
          end
        end
        S_ASG_LEN: begin
          len_n <= len_rd;
          m     <= '0;
          if (len_rd == 4'd0) begin
            n <= n + CntW'(1);
          end else begin
            c_n         <= cand[14:0];
            nxt[len_rd] <= nxt[len_rd] + 16'd1;
          end
        end
        S_CHK_RD: begin
          if (m == n) begin
            n <= n + CntW'(1);
          end
        end
        S_CHK_CMP: begin
          if (overlap) begin
            valid  <= 1'b0;
            status <= StBuildErr;
            done   <= 1'b1;
          end else begin
            m <= m + CntW'(1);
          end
        end
        S_SCAN_RD: begin
          if (n == act) begin
            done <= 1'b1;
            if (!branch) begin
              status <= StNoBranch;
            end else if (found) begin
              status      <= StSymbol;
              symbol      <= fsym;
              path_bits   <= npval;
              path_length <= nplen;
              pval        <= '0;
              pmsb        <= '0;
              plen        <= '0;
            end else begin
              status <= StNeedMore;
              pval   <= npval;
              pmsb   <= npmsb;
              plen   <= nplen;
            end
          end
        end
        S_SCAN_CHK: begin
          if (match) begin
            branch <= 1'b1;
            if (!found && len_rd == nplen) begin
              found <= 1'b1;
              fsym  <= 9'(n);
            end
          end
          n <= n + CntW'(1);
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

  // A result is only ever shown once the block has gone back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // A load completes in the cycle after it is accepted, with status done.
  a_load_one: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == ReqLoad) |=> (done && status == StDone))
    else $error("load did not complete in one cycle");

  // A decoded symbol always carries a nonzero code length.
  a_sym_len: assert property (@(posedge clk) disable iff (rst)
    (done && status == StSymbol) |-> (path_length != 4'd0))
    else $error("decoded symbol with empty path");

endmodule

// ===== dv/canonical_huffman_build_and_decode_core_tb.sv =====
module canonical_huffman_build_and_decode_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chb_pkg::*;

  localparam int NumSymbols = DefMaxSymbols;

  typedef struct {
    logic [2:0]  st;
    logic [8:0]  sym;
    logic [14:0] bits;
    logic [3:0]  len;
  } huff_result_t;

  // Tracks the code tables and the decode walk, and holds the results still owed.
  class huffman_scoreboard;
    bit [3:0]     lens [NumSymbols];
    bit [14:0]    codes [NumSymbols];
    bit [8:0]     count_per_len [16];
    bit [15:0]    first_code [16];
    int           active;
    bit [14:0]    walk_bits;
    bit [3:0]     walk_len;
    bit           built;
    huff_result_t owed [$];
    int           errors;

    function bit assign_codes();
      int c;
      int l;
      int lm;
      foreach (count_per_len[i]) count_per_len[i] = '0;
      for (int n = 0; n < active; n++) count_per_len[lens[n]] += 9'd1;
      count_per_len[0] = '0;
      first_code[0] = '0;
      for (int b = 1; b < 16; b++)
        first_code[b] = 16'((int'(first_code[b-1]) + int'(count_per_len[b-1])) << 1);
      for (int n = 0; n < active; n++) begin
        l = lens[n];
        if (l == 0) continue;
        c = int'(first_code[l]) & ((1 << l) - 1);
        first_code[l] += 16'd1;
        for (int m = 0; m < n; m++) begin
          lm = lens[m];
          if (lm == 0 || lm > l) continue;
          if (int'(codes[m]) == (c >> (l - lm))) return 1'b0;
        end
        codes[n] = 15'(c);
      end
      return 1'b1;
    endfunction

    function bit prefix_of(int s, int plen, int pval);
      int l;
      l = lens[s];
      if (l == 0 || l < plen) return 1'b0;
      for (int i = 0; i < plen; i++)
        if (((int'(codes[s]) >> (l - 1 - i)) & 1) != ((pval >> i) & 1)) return 1'b0;
      return 1'b1;
    endfunction

    function void note_request(logic [1:0] rq, logic [8:0] idx, logic [3:0] cl,
                               logic [8:0] cnt, logic b);
      huff_result_t r;
      int  plen;
      int  pval;
      bit  branch;
      bit  found;
      r = '{StDone, 9'd0, 15'd0, 4'd0};
      case (rq)
        ReqLoad: begin
          if (idx < NumSymbols) lens[idx] = cl;
          built = 1'b0;
          walk_bits = '0;
          walk_len = '0;
        end
        ReqBuild: begin
          active = (cnt > NumSymbols) ? NumSymbols : int'(cnt);
          walk_bits = '0;
          walk_len = '0;
          built = assign_codes();
          if (!built) r.st = StBuildErr;
        end
        ReqDecode: begin
          if (!built) r.st = StNotBuilt;
          else if (walk_len >= 15) r.st = StNoBranch;
          else begin
            plen = walk_len + 1;
            pval = int'(walk_bits) | (int'(b) << walk_len);
            branch = 1'b0;
            found = 1'b0;
            for (int s = 0; s < active; s++) begin
              if (prefix_of(s, plen, pval)) begin
                branch = 1'b1;
                if (!found && lens[s] == plen) begin
                  found = 1'b1;
                  r.sym = 9'(s);
                end
              end
            end
            if (!branch) r.st = StNoBranch;
            else if (found) begin
              r.st = StSymbol;
              r.bits = 15'(pval);
              r.len = 4'(plen);
              walk_bits = '0;
              walk_len = '0;
            end else begin
              r.st = StNeedMore;
              walk_bits = 15'(pval);
              walk_len = 4'(plen);
            end
          end
        end
        default: begin
          walk_bits = '0;
          walk_len = '0;
        end
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [8:0] sym, logic [14:0] bits,
                               logic [3:0] len);
      huff_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result status=%0d symbol=%0d", $time, st, sym);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (st !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, st);
        errors++;
      end
      if (sym !== e.sym) begin
        $display("%0t: symbol expected %0d actual %0d", $time, e.sym, sym);
        errors++;
      end
      if (bits !== e.bits) begin
        $display("%0t: path_bits expected %h actual %h", $time, e.bits, bits);
        errors++;
      end
      if (len !== e.len) begin
        $display("%0t: path_length expected %0d actual %0d", $time, e.len, len);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = ReqRoot;
  logic [8:0]  symbol_index = '0;
  logic [3:0]  code_length = '0;
  logic [8:0]  symbol_count = '0;
  logic        bit_req = 1'b0;
  logic        done;
  logic [2:0]  status;
  logic [8:0]  symbol;
  logic [14:0] path_bits;
  logic [3:0]  path_length;

  huffman_scoreboard sb = new();
  int  idle_pct = 0;
  int  sent = 0;
  int  plan [NumSymbols];

  canonical_huffman_build_and_decode_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .symbol_index(symbol_index), .code_length(code_length),
    .symbol_count(symbol_count), .bit_req(bit_req), .done(done), .status(status),
    .symbol(symbol), .path_bits(path_bits), .path_length(path_length)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, symbol, path_bits, path_length);
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send(logic [1:0] rq, int idx, int cl, int cnt, bit b);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= rq;
    symbol_index <= 9'(idx);
    code_length <= 4'(cl);
    symbol_count <= 9'(cnt);
    bit_req <= b;
    do @(posedge clk); while (busy);
    sb.note_request(rq, 9'(idx), 4'(cl), 9'(cnt), b);
    sent++;
  endtask

  task automatic load_len(int idx, int cl);
    send(ReqLoad, idx, cl, $urandom_range(511), 1'($urandom_range(1)));
  endtask

  task automatic build(int cnt);
    send(ReqBuild, $urandom_range(511), $urandom_range(15), cnt, 1'($urandom_range(1)));
  endtask

  task automatic decode_bit(bit b);
    send(ReqDecode, $urandom_range(511), $urandom_range(15), $urandom_range(511), b);
  endtask

  task automatic to_root();
    send(ReqRoot, $urandom_range(511), $urandom_range(15), $urandom_range(511),
         1'($urandom_range(1)));
  endtask

  task automatic drain();
    if (start) start <= 1'b0;
    while (sb.owed.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Fills plan[0..n-1] with a prefix-free length set by splitting leaves of a
  // binary tree, then scatters unused symbols among them.
  task automatic plan_lengths(int n);
    int leaves [$];
    int k;
    int p;
    int t;
    k = n - $urandom_range(n / 4);
    if (k < 2) k = 2;
    leaves = '{1, 1};
    while (leaves.size() < k) begin
      p = $urandom_range(leaves.size() - 1);
      if (leaves[p] >= 15) begin
        p = -1;
        foreach (leaves[i]) if (leaves[i] < 15) p = i;
        if (p < 0) break;
      end
      t = leaves[p] + 1;
      leaves.delete(p);
      leaves.push_back(t);
      leaves.push_back(t);
    end
    for (int i = 0; i < n; i++) plan[i] = (i < leaves.size()) ? leaves[i] : 0;
    for (int i = n - 1; i > 0; i--) begin
      p = $urandom_range(i);
      t = plan[i];
      plan[i] = plan[p];
      plan[p] = t;
    end
  endtask

  task automatic walk_symbol(int n);
    int s;
    int l;
    s = $urandom_range(n - 1);
    for (int tries = 0; tries < 50 && sb.lens[s] == 0; tries++) s = $urandom_range(n - 1);
    l = sb.lens[s];
    for (int i = 0; i < l; i++) begin
      if ($urandom_range(99) < 6) decode_bit(1'($urandom_range(1)));
      else decode_bit(1'((sb.codes[s] >> (l - 1 - i)) & 1));
      if ($urandom_range(99) < 2) to_root();
    end
  endtask

  task automatic run_episode(bit full);
    int n;
    int cnt;
    int syms;
    n = full ? NumSymbols : $urandom_range(40, 2);
    plan_lengths(n);
    if ($urandom_range(99) < 10) plan[$urandom_range(n - 1)] = 0;
    if ($urandom_range(99) < 8) plan[$urandom_range(n - 1)] = $urandom_range(15, 1);
    if ($urandom_range(99) < 5) foreach (plan[i]) plan[i] = $urandom_range(15);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) load_len($urandom_range(511, NumSymbols),
                                           $urandom_range(15));
      load_len(i, plan[i]);
    end
    cnt = n;
    if ($urandom_range(99) < 5) cnt = $urandom_range(n);
    if (full) cnt = $urandom_range(511, NumSymbols);
    build(cnt);
    syms = full ? 6 : $urandom_range(25, 8);
    for (int k = 0; k < syms; k++) begin
      walk_symbol(n);
      if ($urandom_range(99) < 1) load_len($urandom_range(n - 1), plan[0]);
    end
  endtask

  initial begin
    int episode;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: decode before any build, empty build, a short table,
    // conflicts, a later shorter code and the longest codes.
    decode_bit(1'b1);
    build(0);
    decode_bit(1'b0);
    load_len(0, 1);
    load_len(1, 2);
    load_len(2, 2);
    build(3);
    decode_bit(1'b0);
    decode_bit(1'b1);
    decode_bit(1'b1);
    decode_bit(1'b1);
    to_root();
    decode_bit(1'b1);
    decode_bit(1'b0);
    load_len(400, 15);
    decode_bit(1'b0);
    load_len(1, 1);
    build(3);
    decode_bit(1'b0);
    load_len(0, 2);
    build(2);
    decode_bit(1'b1);
    decode_bit(1'b0);
    load_len(0, 15);
    load_len(1, 15);
    build(2);
    repeat (15) decode_bit(1'b0);
    drain();

    episode = 0;
    while (sent < 1700) begin
      case ((sent / 425) % 4)
        0: idle_pct = 0;
        1: idle_pct = 49;
        2: idle_pct = 0;
        default: idle_pct = 16;
      endcase
      run_episode(episode == 3 || episode == 30 || episode == 60);
      if (episode == 12) drain();
      episode++;
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
